### rtl/gcd_pkg.sv
// Shared constants and elaboration-time table functions for gain_clip_distortion.
package gcd_pkg;

  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int TANH_SEGMENTS_DEF = 64;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_BYPASS      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOFT_MODE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INPUT_GAIN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_SCALE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_GAIN = 3'd6;

  localparam int INPUT_GAIN_W  = 14;
  localparam int THRESHOLD_W   = 24;
  localparam int CLIP_SCALE_W  = 15;
  localparam int DRIVE_W       = 16;
  localparam int OUTPUT_GAIN_W = 15;

  // Gains have 12 fraction bits: drive is Q4.12, input gain Q2.12, clip scale and output gain Q3.12
  localparam int GAIN_FRAC = 12;

  localparam logic [63:0] Q31 = 64'd1 << 31;

  // Unsigned 64-bit quotient by shift and subtract.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Ratio exp(-h) in Q0.31 from the Taylor series truncated after the h^24 term.
  function automatic logic [63:0] exp_ratio(input logic [63:0] h);
    logic [63:0] term;
    longint      sum;
    term = Q31;
    sum  = longint'(Q31);
    for (int i = 1; i <= 24; i++) begin
      term = udiv64((term * h) >> 31, 64'(i));
      if ((i & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return 64'(sum);
  endfunction

  // Table point k of the tanh curve: (1-e)/(1+e) scaled by 2^fracb, e = r^k.
  function automatic logic [63:0] tanh_point(input int k, input logic [63:0] r,
                                             input int fracb);
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    e = Q31;
    for (int j = 0; j < k; j++) begin
      e = (e * r) >> 31;
    end
    num = (Q31 - e) << fracb;
    den = Q31 + e;
    return udiv64(num + (den >> 1), den);
  endfunction

endpackage

### rtl/gain_clip_distortion.sv
// Top level of gain_clip_distortion: gain, hard or tanh soft clip, output gain.
//
// Usage:
//   Input channel: sample_valid / sample_stall / sample_in carry one signed
//   Q1.(SAMPLE_BITS-1) audio request. A request is taken at a rising edge
//   with sample_valid high and sample_stall low.
//   Output channel: result_valid / result_stall / sample_out / saturated
//   return one processed sample per request, in order.
//   Configuration: cfg_write, cfg_index, cfg_data write one register per
//   edge; write only while no request is in flight.
// Pipeline:
//   Seven register stages. One request per cycle is accepted while the
//   output drains. The stages are, in order: input gain, clamp and drive,
//   clip scale and tanh lookup, tanh interpolation, hard or soft pick,
//   output gain, round and saturate.
// Reset (rst, synchronous, active high) empties every stage and loads the
// register defaults (gain 1.0, hard clip, full-scale threshold, output 2.0).
// Stall: a full stage holds while the stage after it is full and held, so
// empty stages keep filling while result_stall holds the full stages at the
// end; once every stage is full and held, sample_stall rises.
module gain_clip_distortion
  import gcd_pkg::*;
#(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int TANH_SEGMENTS = TANH_SEGMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          saturated,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int S    = SAMPLE_BITS;
  localparam int F    = S - 1;
  localparam int NST  = 7;
  // stage widths
  localparam int AW   = S + 3;                      // after input gain
  localparam int CW   = (AW > 26) ? AW : 26;        // clamp domain
  localparam int BW   = AW + 5;                     // tanh argument
  localparam int HW   = CW + 4;                     // after clip scale, combined value
  localparam int TW   = F + 2;                      // tanh table points
  localparam int KW   = $clog2(TANH_SEGMENTS + 1);  // segment index
  localparam int LB   = F + 3;                      // tanh limit bit (8.0)
  localparam int PW   = LB + KW;
  localparam int YW   = HW + 4;
  localparam logic [63:0] STEP  = (64'd16 << 31) / 64'(TANH_SEGMENTS);
  localparam logic [63:0] RATIO = exp_ratio(STEP);
  localparam logic signed [YW-1:0] MAXV = YW'((64'd1 << F) - 64'd1);
  localparam logic signed [YW-1:0] MINV = -(YW'(64'd1 << F));

  // ---------------------------------------------------------------- config
  logic                     bypass;
  logic                     soft_clip_mode;
  logic [INPUT_GAIN_W-1:0]  input_gain;
  logic [THRESHOLD_W-1:0]   clip_threshold;
  logic [CLIP_SCALE_W-1:0]  clip_scale;
  logic [DRIVE_W-1:0]       drive;
  logic [OUTPUT_GAIN_W-1:0] output_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass         <= 1'b0;
      soft_clip_mode <= 1'b0;
      input_gain     <= INPUT_GAIN_W'(4096);
      clip_threshold <= THRESHOLD_W'(8388608);
      clip_scale     <= CLIP_SCALE_W'(4096);
      drive          <= '0;
      output_gain    <= OUTPUT_GAIN_W'(8192);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BYPASS:      bypass         <= cfg_data[0];
        CFG_SOFT_MODE:   soft_clip_mode <= cfg_data[0];
        CFG_INPUT_GAIN:  input_gain     <= cfg_data[INPUT_GAIN_W-1:0];
        CFG_THRESHOLD:   clip_threshold <= cfg_data[THRESHOLD_W-1:0];
        CFG_CLIP_SCALE:  clip_scale     <= cfg_data[CLIP_SCALE_W-1:0];
        CFG_DRIVE:       drive          <= cfg_data[DRIVE_W-1:0];
        CFG_OUTPUT_GAIN: output_gain    <= cfg_data[OUTPUT_GAIN_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------- tanh table
  // Points are fixed at elaboration; the table is read twice per cycle.
  logic signed [TW-1:0] tanh_tbl [0:TANH_SEGMENTS];

  for (genvar k = 0; k <= TANH_SEGMENTS; k++) begin : g_tbl
    localparam logic [63:0] POINT = tanh_point(k, RATIO, F);
    assign tanh_tbl[k] = TW'(POINT);
  end

  // ------------------------------------------------------ stage control
  // A stage loads when it is empty or the stage after it loads.
  logic [NST:1] vld;
  logic [NST:1] ld;

  always_comb begin
    ld[NST] = !vld[NST] || !result_stall;
    for (int i = NST - 1; i >= 1; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  assign sample_stall = !ld[1];
  assign result_valid = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[1]) begin
        vld[1] <= sample_valid;
      end
      for (int i = 2; i <= NST; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // The raw sample rides along for bypass.
  logic signed [S-1:0] raw [1:NST-1];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      raw[1] <= sample_in;
    end
    for (int i = 2; i <= NST - 1; i++) begin
      if (ld[i]) begin
        raw[i] <= raw[i-1];
      end
    end
  end

  // ------------------------------------------------ stage 1: input gain
  logic signed [S+14:0] in_prod;
  logic signed [S+14:0] in_rnd;
  logic signed [AW-1:0] a1;

  assign in_prod = sample_in * $signed({1'b0, input_gain});
  assign in_rnd  = in_prod + (S+15)'(2048);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      a1 <= in_rnd[S+14:GAIN_FRAC];
    end
  end

  // ------------------------------------- stage 2: clamp and drive product
  logic signed [CW-1:0] a_ext;
  logic signed [CW-1:0] thr;
  logic signed [CW-1:0] clamp;
  logic signed [AW+16:0] drv_prod;
  logic signed [AW+16:0] drv_rnd;
  logic signed [CW-1:0] h2;
  logic signed [BW-1:0] b2;

  assign a_ext    = CW'(a1);
  assign thr      = $signed(CW'({1'b0, clip_threshold}));
  assign drv_prod = a1 * $signed({1'b0, drive});
  assign drv_rnd  = drv_prod + (AW+17)'(2048);

  always_comb begin
    if (a_ext >= thr) begin
      clamp = thr;
    end else if (a_ext <= -thr) begin
      clamp = -thr;
    end else begin
      clamp = a_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      h2 <= clamp;
      b2 <= drv_rnd[AW+16:GAIN_FRAC];
    end
  end

  // ----------------------------- stage 3: clip scale and tanh segment lookup
  logic signed [CW+15:0] scl_prod;
  logic signed [CW+15:0] scl_rnd;
  logic                  b_neg;
  logic [BW-1:0]         b_mag;
  logic                  b_big;
  logic [PW-1:0]         seg_pos;
  logic [KW-1:0]         seg;
  logic signed [HW-1:0]  hc3;
  logic                  neg3;
  logic signed [TW-1:0]  t0_3;
  logic signed [TW-1:0]  t1_3;
  logic [15:0]           f3;

  assign scl_prod = h2 * $signed({1'b0, clip_scale});
  assign scl_rnd  = scl_prod + (CW+16)'(2048);
  assign b_neg    = b2[BW-1];
  assign b_mag    = b_neg ? BW'(-b2) : BW'(b2);
  assign b_big    = |b_mag[BW-1:LB];
  assign seg_pos  = PW'(b_mag[LB-1:0]) * PW'(TANH_SEGMENTS);
  assign seg      = seg_pos[PW-1:LB];

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      hc3  <= scl_rnd[CW+15:GAIN_FRAC];
      neg3 <= b_neg;
      if (b_big) begin
        // saturate at the last table point
        t0_3 <= tanh_tbl[TANH_SEGMENTS];
        t1_3 <= tanh_tbl[TANH_SEGMENTS];
        f3   <= '0;
      end else begin
        t0_3 <= tanh_tbl[seg];
        t1_3 <= tanh_tbl[KW'(seg + KW'(1))];
        f3   <= seg_pos[LB-1:LB-16];
      end
    end
  end

  // ---------------------------------------- stage 4: tanh interpolation
  logic signed [TW:0]    t_diff;
  logic signed [TW+17:0] ip_prod;
  logic signed [TW+17:0] ip_rnd;
  logic signed [HW-1:0]  hc4;
  logic                  neg4;
  logic signed [TW-1:0]  t0_4;
  logic signed [TW+1:0]  d4;

  assign t_diff  = (TW+1)'(t1_3) - (TW+1)'(t0_3);
  assign ip_prod = t_diff * $signed({1'b0, f3});
  assign ip_rnd  = ip_prod + (TW+18)'(32768);

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      hc4  <= hc3;
      neg4 <= neg3;
      t0_4 <= t0_3;
      d4   <= ip_rnd[TW+17:16];
    end
  end

  // ---------------------------------------------- stage 5: pick clip value
  logic signed [TW+2:0] y_soft;
  logic signed [HW-1:0] c5;

  assign y_soft = (TW+3)'(t0_4) + (TW+3)'(d4);

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      if (soft_clip_mode) begin
        c5 <= neg4 ? -HW'(y_soft) : HW'(y_soft);
      end else begin
        c5 <= hc4;
      end
    end
  end

  // ---------------------------------------------- stage 6: output gain
  logic signed [HW+15:0] p6;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      p6 <= c5 * $signed({1'b0, output_gain});
    end
  end

  // ---------------------------------------- stage 7: round and saturate
  logic signed [HW+15:0] out_rnd;
  logic signed [YW-1:0]  y7;

  assign out_rnd = p6 + (HW+16)'(2048);
  assign y7      = out_rnd[HW+15:GAIN_FRAC];

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      if (bypass) begin
        sample_out <= raw[NST-1];
        saturated  <= 1'b0;
      end else if (y7 > MAXV) begin
        sample_out <= S'(MAXV);
        saturated  <= 1'b1;
      end else if (y7 < MINV) begin
        sample_out <= S'(MINV);
        saturated  <= 1'b1;
      end else begin
        sample_out <= S'(y7);
        saturated  <= 1'b0;
      end
    end
  end

endmodule
